// File: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	// Default configuration
	localparam int unsigned DEPTH_DEF          = 32;
	localparam int unsigned VALUE_WIDTH_DEF    = 32;
	localparam int unsigned PRIORITY_WIDTH_DEF = 16;

	// Fixed field widths of the request and response payloads
	localparam int unsigned REQ_TYPE_W   = 2;
	localparam int unsigned ITEM_VALUE_W = 32;
	localparam int unsigned ITEM_PRIO_W  = 16;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned COUNT_W      = 6;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_ENQ = 2'd0,
		REQ_DEQ = 2'd1,
		REQ_CLR = 2'd2
	} spq_req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0]          req_type;
		logic [ITEM_VALUE_W-1:0]        item_value;
		logic signed [ITEM_PRIO_W-1:0]  item_priority;
	} spq_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [ITEM_VALUE_W-1:0] head_value;
		logic [COUNT_W-1:0]      entry_count;
		logic                    is_empty;
		logic                    is_full;
	} spq_rsp_t;

	// Per-cell control: the operation applied this cycle and where the cell sits
	typedef struct packed {
		logic enq;       // accepted enqueue that fits
		logic deq;       // accepted dequeue on a non-empty queue
		logic occupied;  // cell index below the count
		logic at_tail;   // cell index equals the count
	} spq_cell_ctl_t;

endpackage

// File: rtl/core/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: cell chain, count and response register.
//
// Usage
//   Request channel (req_valid / req_ready / req): one request per accepted
//   handshake, an enqueue, a dequeue or a clear. Response channel
//   (rsp_valid / rsp_ready / rsp): exactly one response per request, in order,
//   with status, removed head value, count and empty / full flags.
//   Entries sit in a row of DEPTH cells sorted by priority, highest at cell 0.
//   On an enqueue every cell compares the new priority with its own at once
//   and shifts toward the tail or takes the new entry; a dequeue shifts the
//   whole row one cell toward the head.
//   The response is registered and valid in the cycle after the request is accepted.
//   Throughput: one request per cycle; a request is taken whenever the
//   response register is empty or being drained in the same cycle.
//   Stall: while rsp_valid is high and rsp_ready low the response holds and
//   req_ready is low, so no request is lost.
//   Reset: arst_n clears the count and the response valid; cell contents are
//   not cleared, since only entries below the count are ever read.
module sorted_priority_queue_unit #(
	parameter int unsigned DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int unsigned VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int unsigned PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  spq_pkg::spq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output spq_pkg::spq_rsp_t rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic          accept;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          rsp_valid_q;
	spq_pkg::spq_rsp_t rsp_q;
	spq_pkg::spq_rsp_t rsp_nxt;

	logic do_enq;
	logic do_deq;
	logic is_full_now;
	logic is_empty_now;
	logic [spq_pkg::STATUS_W-1:0] status_nxt;

	logic [VALUE_WIDTH-1:0]           new_value;
	logic signed [PRIORITY_WIDTH-1:0] new_prio;
	logic [spq_pkg::ITEM_VALUE_W-1:0] head_ext;
	logic [spq_pkg::COUNT_W-1:0]      count_ext;

	logic [VALUE_WIDTH-1:0]           cell_value [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] cell_prio  [DEPTH];
	logic                             cell_gt    [DEPTH];

	// Accept while the response slot is free or draining this cycle
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_full_now  = (count_q == CW'(DEPTH));
	assign is_empty_now = (count_q == '0);

	// Fit the fixed-width payload fields to the configured storage widths
	generate
		if (VALUE_WIDTH <= spq_pkg::ITEM_VALUE_W) begin : g_val_narrow
			assign new_value = req.item_value[VALUE_WIDTH-1:0];
			if (VALUE_WIDTH == spq_pkg::ITEM_VALUE_W) begin : g_head_eq
				assign head_ext = cell_value[0];
			end else begin : g_head_pad
				assign head_ext = {{(spq_pkg::ITEM_VALUE_W - VALUE_WIDTH){1'b0}},
					cell_value[0]};
			end
		end else begin : g_val_wide
			assign new_value = {{(VALUE_WIDTH - spq_pkg::ITEM_VALUE_W){1'b0}},
				req.item_value};
			assign head_ext  = cell_value[0][spq_pkg::ITEM_VALUE_W-1:0];
		end

		// Priorities wrap to the stored width, two's complement
		if (PRIORITY_WIDTH <= spq_pkg::ITEM_PRIO_W) begin : g_prio_narrow
			assign new_prio = req.item_priority[PRIORITY_WIDTH-1:0];
		end else begin : g_prio_wide
			assign new_prio = {{(PRIORITY_WIDTH - spq_pkg::ITEM_PRIO_W)
				{req.item_priority[spq_pkg::ITEM_PRIO_W-1]}}, req.item_priority};
		end

		// Reported count is the low bits of the internal count
		if (CW >= spq_pkg::COUNT_W) begin : g_cnt_trunc
			assign count_ext = count_nxt[spq_pkg::COUNT_W-1:0];
		end else begin : g_cnt_pad
			assign count_ext = {{(spq_pkg::COUNT_W - CW){1'b0}}, count_nxt};
		end
	endgenerate

	// Request decode
	always_comb begin
		do_enq     = 1'b0;
		do_deq     = 1'b0;
		count_nxt  = count_q;
		status_nxt = spq_pkg::ST_OK;
		unique case (req.req_type)
			spq_pkg::REQ_ENQ: begin
				if (is_full_now) begin
					status_nxt = spq_pkg::ST_FULL;
				end else begin
					do_enq    = accept;
					count_nxt = count_q + CW'(1);
				end
			end
			spq_pkg::REQ_DEQ: begin
				if (is_empty_now) begin
					status_nxt = spq_pkg::ST_EMPTY;
				end else begin
					do_deq    = accept;
					count_nxt = count_q - CW'(1);
				end
			end
			spq_pkg::REQ_CLR: begin
				count_nxt = '0;
			end
			default: begin
				// unused request code: no effect
			end
		endcase
	end

	always_comb begin
		rsp_nxt.status      = status_nxt;
		rsp_nxt.head_value  = (req.req_type == spq_pkg::REQ_DEQ && !is_empty_now) ?
			head_ext : '0;
		rsp_nxt.entry_count = count_ext;
		rsp_nxt.is_empty    = (count_nxt == '0);
		rsp_nxt.is_full     = (count_nxt == CW'(DEPTH));
	end

	// Cell chain: each cell sees its upstream neighbor for enqueue shifts and
	// its downstream neighbor for dequeue shifts
	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			spq_pkg::spq_cell_ctl_t           ctl;
			logic                             prev_gt;
			logic [VALUE_WIDTH-1:0]           prev_value;
			logic signed [PRIORITY_WIDTH-1:0] prev_prio;
			logic [VALUE_WIDTH-1:0]           next_value;
			logic signed [PRIORITY_WIDTH-1:0] next_prio;

			assign ctl.enq      = do_enq;
			assign ctl.deq      = do_deq;
			assign ctl.occupied = (count_q > CW'(i));
			assign ctl.at_tail  = (count_q == CW'(i));

			if (i == 0) begin : g_head
				assign prev_gt    = 1'b0;
				assign prev_value = new_value;
				assign prev_prio  = new_prio;
			end else begin : g_mid
				assign prev_gt    = cell_gt[i-1];
				assign prev_value = cell_value[i-1];
				assign prev_prio  = cell_prio[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign next_value = cell_value[i];
				assign next_prio  = cell_prio[i];
			end else begin : g_body
				assign next_value = cell_value[i+1];
				assign next_prio  = cell_prio[i+1];
			end

			spq_cell #(
				.VALUE_WIDTH    (VALUE_WIDTH),
				.PRIORITY_WIDTH (PRIORITY_WIDTH)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.new_value  (new_value),
				.new_prio   (new_prio),
				.prev_gt    (prev_gt),
				.prev_value (prev_value),
				.prev_prio  (prev_prio),
				.next_value (next_value),
				.next_prio  (next_prio),
				.gt         (cell_gt[i]),
				.value      (cell_value[i]),
				.prio       (cell_prio[i])
			);
		end
	endgenerate

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

// File: rtl/core/spq_cell.sv
// One storage cell of the sorted queue: holds an entry and shifts with its neighbors.
module spq_cell #(
	parameter int unsigned VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int unsigned PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic                             clk,
	input  spq_pkg::spq_cell_ctl_t           ctl,
	input  logic [VALUE_WIDTH-1:0]           new_value,
	input  logic signed [PRIORITY_WIDTH-1:0] new_prio,
	input  logic                             prev_gt,
	input  logic [VALUE_WIDTH-1:0]           prev_value,
	input  logic signed [PRIORITY_WIDTH-1:0] prev_prio,
	input  logic [VALUE_WIDTH-1:0]           next_value,
	input  logic signed [PRIORITY_WIDTH-1:0] next_prio,
	output logic                             gt,
	output logic [VALUE_WIDTH-1:0]           value,
	output logic signed [PRIORITY_WIDTH-1:0] prio
);

	logic [VALUE_WIDTH-1:0]           value_q;
	logic signed [PRIORITY_WIDTH-1:0] prio_q;

	// New entry outranks this one; ties keep arrival order
	assign gt    = ctl.occupied && (new_prio > prio_q);
	assign value = value_q;
	assign prio  = prio_q;

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (gt || ctl.at_tail) begin
				if (prev_gt) begin
					value_q <= prev_value;
					prio_q  <= prev_prio;
				end else begin
					value_q <= new_value;
					prio_q  <= new_prio;
				end
			end
		end else if (ctl.deq) begin
			value_q <= next_value;
			prio_q  <= next_prio;
		end
	end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the sorted priority queue unit.
`timescale 1ns / 1ps

module testbench;

	// Request kind with no enum member: the block must ignore it
	localparam logic [spq_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned QUEUE_DEPTH = spq_pkg::DEPTH_DEF;

	// Mirror of the queue contents plus the responses still owed by the block
	class queue_scoreboard;
		logic [spq_pkg::ITEM_VALUE_W-1:0]       held_values[$];
		logic signed [spq_pkg::ITEM_PRIO_W-1:0] held_prios[$];
		spq_pkg::spq_rsp_t                      owed_replies[$];
		int unsigned                            mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Predict the response for an accepted request and update the mirror
		function void note_request(spq_pkg::spq_req_t r);
			spq_pkg::spq_rsp_t reply;
			int unsigned       slot;
			reply = '0;
			reply.status = spq_pkg::ST_OK;
			case (r.req_type)
				spq_pkg::REQ_ENQ: begin
					if (held_values.size() >= QUEUE_DEPTH) begin
						reply.status = spq_pkg::ST_FULL;
					end else begin
						// behind every entry of higher or equal priority
						slot = held_values.size();
						for (int i = 0; i < held_values.size(); i++) begin
							if (r.item_priority > held_prios[i]) begin
								slot = i;
								break;
							end
						end
						held_values.insert(slot, r.item_value);
						held_prios.insert(slot, r.item_priority);
					end
				end
				spq_pkg::REQ_DEQ: begin
					if (held_values.size() == 0) begin
						reply.status = spq_pkg::ST_EMPTY;
					end else begin
						reply.head_value = held_values.pop_front();
						void'(held_prios.pop_front());
					end
				end
				spq_pkg::REQ_CLR: begin
					held_values.delete();
					held_prios.delete();
				end
				default: begin
				end
			endcase
			reply.entry_count = (spq_pkg::COUNT_W)'(held_values.size());
			reply.is_empty    = (held_values.size() == 0);
			reply.is_full     = (held_values.size() == QUEUE_DEPTH);
			owed_replies.push_back(reply);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		endtask

		task check_response(spq_pkg::spq_rsp_t got);
			spq_pkg::spq_rsp_t want;
			if (owed_replies.size() == 0) begin
				report_mismatch("response with none outstanding", 64'(got), '0);
				return;
			end
			want = owed_replies.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.head_value !== want.head_value)
				report_mismatch("head_value", 64'(got.head_value), 64'(want.head_value));
			if (got.entry_count !== want.entry_count)
				report_mismatch("entry_count", 64'(got.entry_count),
					64'(want.entry_count));
			if (got.is_empty !== want.is_empty)
				report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
			if (got.is_full !== want.is_full)
				report_mismatch("is_full", 64'(got.is_full), 64'(want.is_full));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	spq_pkg::spq_req_t req;
	logic              rsp_valid;
	logic              rsp_ready;
	spq_pkg::spq_rsp_t rsp;

	// Per-cycle idle chances in percent; changed between phases
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	queue_scoreboard sb = new();

	sorted_priority_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run of about 1000 requests
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Handshakes are sampled at the rising edge; the request is noted before
	// the response is checked so a same-edge pair is always ordered right.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	// Receiver: one decision per falling edge, so ready never toggles twice in a step
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic spq_pkg::spq_req_t make_req(logic [spq_pkg::REQ_TYPE_W-1:0] kind,
			logic [spq_pkg::ITEM_VALUE_W-1:0] val, logic [spq_pkg::ITEM_PRIO_W-1:0] prio);
		spq_pkg::spq_req_t r;
		r.req_type      = kind;
		r.item_value    = val;
		r.item_priority = prio;
		return r;
	endfunction

	// Priorities: mostly a narrow band so ties are common, plus full range and extremes
	function automatic logic [spq_pkg::ITEM_PRIO_W-1:0] pick_priority();
		logic [spq_pkg::ITEM_PRIO_W-1:0] p;
		case ($urandom_range(3))
			0: p = (spq_pkg::ITEM_PRIO_W)'($urandom_range(6) - 3);
			1: p = (spq_pkg::ITEM_PRIO_W)'($urandom);
			2: p = $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: p = (spq_pkg::ITEM_PRIO_W)'($urandom_range(40) - 20);
		endcase
		return p;
	endfunction

	function automatic logic [spq_pkg::ITEM_VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mix of kinds; enq_pct steers the fill level, clears and the unused kind are rare
	function automatic spq_pkg::spq_req_t random_request(int unsigned enq_pct);
		int unsigned                    roll;
		logic [spq_pkg::REQ_TYPE_W-1:0] kind;
		roll = $urandom_range(99);
		if (roll < 2)
			kind = REQ_UNUSED;
		else if (roll < 5)
			kind = spq_pkg::REQ_CLR;
		else if (roll < 5 + enq_pct)
			kind = spq_pkg::REQ_ENQ;
		else
			kind = spq_pkg::REQ_DEQ;
		return make_req(kind, pick_value(), pick_priority());
	endfunction

	// Present one request at a falling edge and hold it until taken
	task automatic send_request(spq_pkg::spq_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	// Sender goes quiet until every response owed has come back
	task automatic hold_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.owed_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_directed();
		send_request(make_req(spq_pkg::REQ_DEQ, 32'h0, 16'h0));    // dequeue when empty
		send_request(make_req(spq_pkg::REQ_CLR, 32'h0, 16'h0));    // clear when empty
		send_request(make_req(REQ_UNUSED, '1, '1));                // unused kind, ignored
		send_request(make_req(spq_pkg::REQ_ENQ, 32'hffff_ffff, 16'h8000)); // lowest priority
		send_request(make_req(spq_pkg::REQ_ENQ, 32'h0, 16'h7fff)); // highest priority
		send_request(make_req(spq_pkg::REQ_ENQ, 32'h1234_5678, 16'h0000));
		send_request(make_req(spq_pkg::REQ_ENQ, 32'h0000_000a, 16'hffff));
		send_request(make_req(spq_pkg::REQ_ENQ, 32'h0000_000b, 16'hffff)); // tie, arrival order
		send_request(make_req(spq_pkg::REQ_ENQ, 32'h0000_000c, 16'h7fff)); // ties with the head
		send_request(make_req(REQ_UNUSED, '0, '0));
		repeat (4) send_request(make_req(spq_pkg::REQ_DEQ, '1, '1));
		send_request(make_req(spq_pkg::REQ_CLR, '1, '1));          // clear with entries left
		send_request(make_req(spq_pkg::REQ_DEQ, 32'h0, 16'h0));    // empty again after clear
		send_request(make_req(spq_pkg::REQ_ENQ, 32'haaaa_aaaa, 16'h5555));
		send_request(make_req(spq_pkg::REQ_ENQ, 32'h5555_5555, 16'haaaa));
		repeat (3) send_request(make_req(spq_pkg::REQ_DEQ, 32'h0, 16'h0));
	endtask

	// Fill past full, then random bursts of varying bias, with an occasional quiet drain
	task automatic run_phase(int unsigned n_items);
		int unsigned sent;
		int unsigned burst;
		int unsigned enq_pct;
		send_request(make_req(spq_pkg::REQ_CLR, pick_value(), pick_priority()));
		sent = 1;
		repeat (QUEUE_DEPTH + 3) begin
			send_request(make_req(spq_pkg::REQ_ENQ, pick_value(), pick_priority()));
			sent++;
		end
		while (sent < n_items) begin
			case ($urandom_range(3))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 48;
			endcase
			burst = $urandom_range(40, 8);
			repeat (burst) begin
				send_request(random_request(enq_pct));
				sent++;
			end
			if ($urandom_range(5) == 0)
				hold_until_drained();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		send_idle_pct  = 18;
		recv_stall_pct = 80;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_phase(300);
		hold_until_drained();

		send_idle_pct  = 80;
		recv_stall_pct = 18;
		run_phase(300);
		hold_until_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_phase(330);

		// Let everything owed arrive, then a few cycles for any stray response
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
tb/testbench.sv
